/* sv/nls_pkg.sv */
// Shared types and constants for the numeric literal scanner.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package nls_pkg;

   // Default limits, handed to the top-level parameters
   localparam int DEF_MAX_LEN    = 99;
   localparam int DEF_HEX_DIGITS = 8;

   // Field widths
   localparam int CH_W     = 8;
   localparam int VALUE_W  = 32;
   localparam int LENGTH_W = 7;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // Largest decimal value before saturation
   localparam logic [35:0] DEC_SAT_LIMIT = 36'd2147483647;

   // Scanner modes
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_DEC    = 3'd1;
   localparam logic [2:0] MODE_HEX    = 3'd2;
   localparam logic [2:0] MODE_ZERO   = 3'd3;
   localparam logic [2:0] MODE_ZEROX  = 3'd4;
   localparam logic [2:0] MODE_SUFFIX = 3'd5;

   // Number kinds
   localparam logic [1:0] KIND_INT    = 2'd0;
   localparam logic [1:0] KIND_FLOAT  = 2'd1;
   localparam logic [1:0] KIND_DOUBLE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_SYNTAX = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;

   // Per-character outcome
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_TAKE = 2'd1;
   localparam logic [1:0] RES_END  = 2'd2;
   localparam logic [1:0] RES_ERR  = 2'd3;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_PAREN = 8'h28;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LD    = 8'h64;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_LG    = 8'h67;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UG    = 8'h47;
   localparam logic [7:0] CH_UZ    = 8'h5A;

   // Character class flags from the decoder
   typedef struct packed {
      logic       is_digit;
      logic       dec_err;
      logic       hex_err;
      logic       hex_sym;
      logic [3:0] hex_val;
      logic       dec_member;
   } char_class_type;

   // One result word, before packing onto the bus
   typedef struct packed {
      logic                done_res;
      logic                taken;
      logic [1:0]          status;
      logic [1:0]          kind;
      logic [VALUE_W-1:0]  int_value;
      logic [LENGTH_W-1:0] length;
      logic                overflow;
   } step_result_type;

endpackage

`default_nettype wire

/* sv/nls_char_class.sv */
// Character decoder: digit, hex symbol and error-letter classes of one byte.
// Depends on nls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nls_char_class
   import nls_pkg::*;
(
   input  wire logic [CH_W-1:0] ch,
   output char_class_type       cls
);

   logic lower, upper, umlaut, digit, af_low, af_up;

   always_comb begin
      lower  = (ch >= CH_LA) && (ch <= CH_LZ);
      upper  = (ch >= CH_UA) && (ch <= CH_UZ);
      digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
      af_low = (ch >= CH_LA) && (ch <= CH_LF);
      af_up  = (ch >= CH_UA) && (ch <= CH_UF);
      umlaut = (ch == 8'hC4) || (ch == 8'hD6) || (ch == 8'hDC) || (ch == 8'hDF) ||
               (ch == 8'hE4) || (ch == 8'hF6) || (ch == 8'hFC);

      cls.is_digit = digit;
      // d, e, f are legal in decimal; every other letter is an error
      cls.dec_err  = (lower && !((ch == CH_LD) || (ch == CH_LE) || (ch == CH_LF))) ||
                     upper || (ch == CH_QMARK) || (ch == CH_PAREN) || umlaut;
      cls.hex_err  = ((ch >= CH_LG) && (ch <= CH_LZ)) || ((ch >= CH_UG) && (ch <= CH_UZ)) ||
                     (ch == CH_QMARK) || (ch == CH_PAREN) || umlaut;
      cls.hex_sym  = digit || af_low || af_up;
      // low nibble of the code gives the digit; letters add nine
      cls.hex_val  = digit ? ch[3:0] : (ch[3:0] + 4'd9);
      cls.dec_member = digit || (ch == CH_DOT) || (ch == CH_MINUS) ||
                       (ch == CH_LE) || (ch == CH_LD) || (ch == CH_LF);
   end

endmodule

`default_nettype wire

/* sv/nls_step.sv */
// Scanner state registers and the next-state / result logic for one word.
// Depends on nls_pkg and the class flags from nls_char_class.
`timescale 1ns / 1ps
`default_nettype none

module nls_step
   import nls_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int HEX_DIGITS = DEF_HEX_DIGITS
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic [CH_W-1:0] ch,
   input  wire logic            first,
   input  wire logic            line_end,
   input  wire char_class_type  cls,
   output step_result_type      result
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);

   logic [2:0]         mode_ff, mode_in;
   logic [CH_W-1:0]    prev_ff, prev_in;
   logic [1:0]         kind_ff, kind_in;
   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               sat_ff, sat_in;
   logic               sfx_f_ff, sfx_f_in;

   // base state the character is applied to
   logic [CH_W-1:0]    b_prev;
   logic [1:0]         b_kind;
   logic [VALUE_W-1:0] b_accum;
   logic [LEN_W-1:0]   b_len;
   logic               b_sat;
   logic               b_sfx;

   // decimal path outcome
   logic [1:0]         d_res;
   logic [2:0]         d_mode;
   logic [CH_W-1:0]    d_prev;
   logic [1:0]         d_kind;
   logic [VALUE_W-1:0] d_accum;
   logic [LEN_W-1:0]   d_len;
   logic               d_sat;
   logic               d_sfx;
   logic               lead_ok;
   logic [35:0]        dec_sum;

   // hex path outcome
   logic [1:0]         h_res;
   logic [VALUE_W-1:0] h_accum;
   logic [LEN_W-1:0]   h_len;
   logic [CH_W-1:0]    h_prev;

   logic [1:0]         res;
   logic [LEN_W-1:0]   len_inc;
   logic               is_dfe;
   logic [7:0]         clash_ch;

   always_comb begin
      // a first character restarts from reset; after "0x" the hex value restarts
      b_prev  = prev_ff;
      b_kind  = kind_ff;
      b_accum = accum_ff;
      b_len   = len_ff;
      b_sat   = sat_ff;
      b_sfx   = sfx_f_ff;
      if (first) begin
         b_prev  = CH_NUL;
         b_kind  = KIND_INT;
         b_accum = '0;
         b_len   = '0;
         b_sat   = 1'b0;
         b_sfx   = 1'b0;
      end else if ((mode_ff == MODE_ZEROX) && !line_end) begin
         b_accum = '0;
         b_len   = '0;
      end
      len_inc = b_len + 1'b1;

      // decimal character
      lead_ok = (b_prev == CH_NUL) || ((b_prev >= CH_ZERO) && (b_prev <= CH_NINE));
      is_dfe  = (ch == CH_LD) || (ch == CH_LE) || (ch == CH_LF);
      dec_sum = ({4'b0, b_accum} << 3) + ({4'b0, b_accum} << 1) + {32'b0, ch[3:0]};
      d_res   = RES_TAKE;
      d_mode  = MODE_DEC;
      d_prev  = b_prev;
      d_kind  = b_kind;
      d_accum = b_accum;
      d_len   = b_len;
      d_sat   = b_sat;
      d_sfx   = b_sfx;
      if (b_len >= LEN_W'(MAX_LEN)) begin
         d_res = RES_END;
      end else if (cls.dec_err) begin
         d_res = RES_ERR;
      end else if (!cls.dec_member) begin
         d_res = RES_END;
      end else if ((ch == CH_MINUS) && (b_prev != CH_LE)) begin
         d_res = RES_END;
      end else if (is_dfe) begin
         if (!(lead_ok || (b_prev == CH_DOT))) begin
            d_res = RES_ERR;
         end else if (ch != CH_LE) begin
            // suffix: not counted, one more character is looked at
            d_kind = (ch == CH_LF) ? KIND_FLOAT : KIND_DOUBLE;
            d_sfx  = (ch == CH_LF);
            d_mode = MODE_SUFFIX;
         end else begin
            d_kind = KIND_DOUBLE;
            d_len  = len_inc;
            d_prev = ch;
         end
      end else if (ch == CH_DOT) begin
         if (!lead_ok) begin
            d_res = RES_ERR;
         end else begin
            d_kind = KIND_DOUBLE;
            d_len  = len_inc;
            d_prev = ch;
         end
      end else begin
         // digit, or minus right after e
         if (cls.is_digit && (b_kind == KIND_INT)) begin
            if (dec_sum > DEC_SAT_LIMIT) begin
               d_accum = DEC_SAT_LIMIT[VALUE_W-1:0];
               d_sat   = 1'b1;
            end else begin
               d_accum = dec_sum[VALUE_W-1:0];
            end
         end
         d_len  = len_inc;
         d_prev = ch;
      end

      // hex character
      h_res   = RES_TAKE;
      h_accum = b_accum;
      h_len   = b_len;
      h_prev  = b_prev;
      if (b_len >= LEN_W'(MAX_LEN)) begin
         h_res = RES_END;
      end else if (b_len >= LEN_W'(HEX_DIGITS)) begin
         h_res = cls.hex_sym ? RES_ERR : RES_END;
      end else if (cls.hex_err) begin
         h_res = RES_ERR;
      end else if (!cls.hex_sym) begin
         h_res = RES_END;
      end else begin
         h_accum = {b_accum[VALUE_W-5:0], cls.hex_val};
         h_len   = len_inc;
         h_prev  = ch;
      end

      // mode dispatch
      clash_ch = sfx_f_ff ? CH_LD : CH_LF;
      res      = RES_NONE;
      mode_in  = mode_ff;
      prev_in  = b_prev;
      kind_in  = b_kind;
      accum_in = b_accum;
      len_in   = b_len;
      sat_in   = b_sat;
      sfx_f_in = b_sfx;
      if (first) begin
         mode_in = MODE_DEC;
         if (line_end) begin
            res = RES_END;
         end else begin
            res      = d_res;
            mode_in  = d_mode;
            prev_in  = d_prev;
            kind_in  = d_kind;
            accum_in = d_accum;
            len_in   = d_len;
            sat_in   = d_sat;
            sfx_f_in = d_sfx;
            if ((d_res == RES_TAKE) && (ch == CH_ZERO) && (d_mode == MODE_DEC)) begin
               mode_in = MODE_ZERO;
            end
         end
      end else begin
         unique case (mode_ff)
            MODE_DEC, MODE_ZERO: begin
               if (line_end) begin
                  res = RES_END;
               end else if ((mode_ff == MODE_ZERO) && (ch == CH_LX)) begin
                  res     = RES_TAKE;
                  mode_in = MODE_ZEROX;
               end else begin
                  res      = d_res;
                  mode_in  = d_mode;
                  prev_in  = d_prev;
                  kind_in  = d_kind;
                  accum_in = d_accum;
                  len_in   = d_len;
                  sat_in   = d_sat;
                  sfx_f_in = d_sfx;
               end
            end
            MODE_HEX, MODE_ZEROX: begin
               if (line_end) begin
                  // "0x" at line end is a syntax error
                  res = (mode_ff == MODE_ZEROX) ? RES_ERR : RES_END;
               end else begin
                  res      = h_res;
                  mode_in  = MODE_HEX;
                  prev_in  = h_prev;
                  accum_in = h_accum;
                  len_in   = h_len;
               end
            end
            MODE_SUFFIX: begin
               if (!line_end && (cls.dec_err || (ch == CH_LE) || (ch == clash_ch))) begin
                  res = RES_ERR;
               end else begin
                  res = RES_END;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end

      result.done_res  = 1'b0;
      result.taken     = 1'b0;
      result.status    = STAT_OK;
      case (res)
         RES_TAKE: result.taken = 1'b1;
         RES_END: begin
            result.done_res = 1'b1;
            result.status   = ((kind_in == KIND_INT) && (len_in == '0)) ? STAT_EMPTY : STAT_OK;
            mode_in         = MODE_IDLE;
         end
         RES_ERR: begin
            result.done_res = 1'b1;
            result.status   = STAT_SYNTAX;
            mode_in         = MODE_IDLE;
         end
         default: ;
      endcase
      result.kind      = kind_in;
      result.int_value = accum_in;
      result.length    = LENGTH_W'(len_in);
      result.overflow  = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         prev_ff  <= CH_NUL;
         kind_ff  <= KIND_INT;
         accum_ff <= '0;
         len_ff   <= '0;
         sat_ff   <= 1'b0;
         sfx_f_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         prev_ff  <= prev_in;
         kind_ff  <= kind_in;
         accum_ff <= accum_in;
         len_ff   <= len_in;
         sat_ff   <= sat_in;
         sfx_f_ff <= sfx_f_in;
      end
   end

endmodule

`default_nettype wire

/* sv/numeric_literal_scanner_core.sv */
// Numeric literal scanner, top level: input register, step logic, result register.
// Depends on nls_pkg, nls_char_class and nls_step.
// Registers: a word taken into the input register moves on to the result register, which drives rsp.
// Throughput: one character per cycle while the rsp side keeps up; the scan state loop is
// combinational between the state registers (class decode, x10 multiply-add and saturate compare, mode select).
// Reset: synchronous, active high; empties both registers and returns the scanner to idle.
`timescale 1ns / 1ps
`default_nettype none

module numeric_literal_scanner_core
   import nls_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,    // 8..127 kept characters
   parameter int HEX_DIGITS = DEF_HEX_DIGITS  // 1..8 hex digits
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request stream: one character per word
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] ch
   input  wire logic [1:0]            req_tuser,   // [0] first, [1] line_end

   // response stream: one result per character
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [0] taken, [2:1] status,
                                                   // [34:3] int_value, [41:35] length,
                                                   // [42] overflow, [47:43] zero
   output logic                       rsp_tlast,   // done_res
   output logic [1:0]                 rsp_tuser    // kind
);

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] ch_ff;
   logic            first_ff;
   logic            line_end_ff;

   // result register
   logic            out_valid_ff, out_valid_in;
   step_result_type out_ff;

   char_class_type  cls;
   step_result_type step_res;
   logic            advance;
   logic            req_fire;

   // The held word moves on whenever the result register is free or being drained;
   // that lets a new word enter every cycle while the downstream keeps up.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff       <= req_tdata[CH_W-1:0];
         first_ff    <= req_tuser[0];
         line_end_ff <= req_tuser[1];
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   nls_char_class u_class (
      .ch  (ch_ff),
      .cls (cls)
   );

   // scan state advances exactly once per word, together with the result register
   nls_step #(
      .MAX_LEN    (MAX_LEN),
      .HEX_DIGITS (HEX_DIGITS)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .ch       (ch_ff),
      .first    (first_ff),
      .line_end (line_end_ff),
      .cls      (cls),
      .result   (step_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.done_res;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {5'b0, out_ff.overflow, out_ff.length, out_ff.int_value,
                        out_ff.status, out_ff.taken};

endmodule

`default_nettype wire

/* sim/nls_checker.sv */
// Scoreboard for the numeric literal scanner: predicts one result word per accepted
// character and compares it with the rsp stream. Depends on nls_pkg.
`timescale 1ns / 1ps

module nls_checker
   import nls_pkg::*;
#(
   parameter int MAX_LEN    = DEF_MAX_LEN,
   parameter int HEX_DIGITS = DEF_HEX_DIGITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] ch
   input  logic [1:0]            req_tuser,   // [0] first, [1] line_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] taken, [2:1] status, [34:3] int_value,
                                              // [41:35] length, [42] overflow, [47:43] zero
   input  logic                  rsp_tlast,   // done_res
   input  logic [1:0]            rsp_tuser,   // kind
   output int                    fail_count,
   output int                    pending,
   output int                    n_checked,
   output int                    n_ok,
   output int                    n_syntax,
   output int                    n_empty,
   output int                    n_saturated
);

   localparam logic [7:0] UMLAUT_CODES [7] = '{8'hC4, 8'hD6, 8'hDC, 8'hDF,
                                               8'hE4, 8'hF6, 8'hFC};

   // scanner state as the predictor sees it
   logic [2:0]  sc_mode;
   logic [7:0]  sc_prev;
   logic [1:0]  sc_kind;
   logic [31:0] sc_accum;
   logic [7:0]  sc_len;
   logic        sc_sat;
   logic        sc_suf_f;

   step_result_type expected_results [$];
   step_result_type want;

   function automatic void clear_scan();
      sc_mode  = MODE_IDLE;
      sc_prev  = CH_NUL;
      sc_kind  = KIND_INT;
      sc_accum = '0;
      sc_len   = '0;
      sc_sat   = 1'b0;
      sc_suf_f = 1'b0;
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_umlaut(logic [7:0] c);
      foreach (UMLAUT_CODES[i])
         if (c == UMLAUT_CODES[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic dec_bad(logic [7:0] c);
      if (c >= CH_LA && c <= CH_LZ) return !(c == CH_LD || c == CH_LE || c == CH_LF);
      if (c >= CH_UA && c <= CH_UZ) return 1'b1;
      return c == CH_QMARK || c == CH_PAREN || is_umlaut(c);
   endfunction

   function automatic logic hex_bad(logic [7:0] c);
      return (c >= CH_LG && c <= CH_LZ) || (c >= CH_UG && c <= CH_UZ) ||
             c == CH_QMARK || c == CH_PAREN || is_umlaut(c);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      logic [7:0] d;
      if (is_dig(c)) begin
         d = c - CH_ZERO;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_LA && c <= CH_LF) begin
         d = c - CH_LA + 8'd10;
         return {1'b1, d[3:0]};
      end
      if (c >= CH_UA && c <= CH_UF) begin
         d = c - CH_UA + 8'd10;
         return {1'b1, d[3:0]};
      end
      return 5'b0;
   endfunction

   function automatic logic [1:0] dec_step(logic [7:0] c);
      logic        lead_ok;
      logic [35:0] acc;
      lead_ok = (sc_prev == CH_NUL) || is_dig(sc_prev);
      if (sc_len >= MAX_LEN) return RES_END;
      if (dec_bad(c)) return RES_ERR;
      if (!(is_dig(c) || c == CH_DOT || c == CH_MINUS || c == CH_LE || c == CH_LD ||
            c == CH_LF))
         return RES_END;
      if (c == CH_MINUS && sc_prev != CH_LE) return RES_END;
      if (c == CH_LE || c == CH_LD || c == CH_LF) begin
         if (!(lead_ok || sc_prev == CH_DOT)) return RES_ERR;
         if (c != CH_LE) begin
            // suffix: not kept, one more look before the end
            sc_kind  = (c == CH_LF) ? KIND_FLOAT : KIND_DOUBLE;
            sc_suf_f = (c == CH_LF);
            sc_mode  = MODE_SUFFIX;
            return RES_TAKE;
         end
         sc_kind = KIND_DOUBLE;
      end
      if (c == CH_DOT) begin
         if (!lead_ok) return RES_ERR;
         sc_kind = KIND_DOUBLE;
      end
      if (is_dig(c) && sc_kind == KIND_INT) begin
         acc = 36'(sc_accum) * 36'd10 + 36'(c - CH_ZERO);
         if (acc > DEC_SAT_LIMIT) begin
            acc    = DEC_SAT_LIMIT;
            sc_sat = 1'b1;
         end
         sc_accum = acc[31:0];
      end
      sc_len  = sc_len + 8'd1;
      sc_prev = c;
      return RES_TAKE;
   endfunction

   function automatic logic [1:0] hex_step(logic [7:0] c);
      logic [4:0] nib;
      nib = hex_nibble(c);
      if (sc_len >= MAX_LEN) return RES_END;
      if (sc_len >= HEX_DIGITS) return nib[4] ? RES_ERR : RES_END;
      if (hex_bad(c)) return RES_ERR;
      if (!nib[4]) return RES_END;
      sc_accum = {sc_accum[27:0], nib[3:0]};
      sc_len   = sc_len + 8'd1;
      sc_prev  = c;
      return RES_TAKE;
   endfunction

   function automatic step_result_type scan_char(logic [7:0] c, logic first, logic le);
      logic [1:0]      res;
      step_result_type r;
      res = RES_NONE;
      if (first) begin
         clear_scan();
         sc_mode = MODE_DEC;
         if (le) res = RES_END;
         else begin
            res = dec_step(c);
            if (res == RES_TAKE && c == CH_ZERO && sc_mode == MODE_DEC) sc_mode = MODE_ZERO;
         end
      end else begin
         case (sc_mode)
            MODE_DEC: begin
               if (le) res = RES_END;
               else res = dec_step(c);
            end
            MODE_HEX: begin
               if (le) res = RES_END;
               else res = hex_step(c);
            end
            MODE_ZERO: begin
               if (le) res = RES_END;
               else if (c == CH_LX) begin
                  res     = RES_TAKE;
                  sc_mode = MODE_ZEROX;
               end else begin
                  sc_mode = MODE_DEC;
                  res     = dec_step(c);
               end
            end
            MODE_ZEROX: begin
               if (le) res = RES_ERR;
               else begin
                  sc_mode  = MODE_HEX;
                  sc_len   = '0;
                  sc_accum = '0;
                  res      = hex_step(c);
               end
            end
            MODE_SUFFIX: begin
               if (!le && (dec_bad(c) || c == CH_LE || c == (sc_suf_f ? CH_LD : CH_LF)))
                  res = RES_ERR;
               else
                  res = RES_END;
            end
            default: sc_mode = MODE_IDLE;
         endcase
      end

      r = '0;
      case (res)
         RES_TAKE: r.taken = 1'b1;
         RES_END: begin
            r.done_res = 1'b1;
            r.status   = (sc_kind == KIND_INT && sc_len == 0) ? STAT_EMPTY : STAT_OK;
            sc_mode    = MODE_IDLE;
         end
         RES_ERR: begin
            r.done_res = 1'b1;
            r.status   = STAT_SYNTAX;
            sc_mode    = MODE_IDLE;
         end
         default: ;
      endcase
      r.kind      = sc_kind;
      r.int_value = sc_accum;
      r.length    = sc_len[LENGTH_W-1:0];
      r.overflow  = sc_sat;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_results.delete();
         fail_count  = 0;
         n_checked   = 0;
         n_ok        = 0;
         n_syntax    = 0;
         n_empty     = 0;
         n_saturated = 0;
      end else begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            expected_results.push_back(scan_char(req_tdata[7:0], req_tuser[0], req_tuser[1]));
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("result word with no character waiting for it");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               n_checked++;
               check_field("done_res", 32'(want.done_res), 32'(rsp_tlast));
               check_field("taken", 32'(want.taken), 32'(rsp_tdata[0]));
               check_field("status", 32'(want.status), 32'(rsp_tdata[2:1]));
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("int_value", want.int_value, rsp_tdata[34:3]);
               check_field("length", 32'(want.length), 32'(rsp_tdata[41:35]));
               check_field("overflow", 32'(want.overflow), 32'(rsp_tdata[42]));
               check_field("pad", 32'd0, 32'(rsp_tdata[47:43]));
               if (want.done_res) begin
                  case (want.status)
                     STAT_OK:     n_ok++;
                     STAT_SYNTAX: n_syntax++;
                     default:     n_empty++;
                  endcase
                  if (want.overflow) n_saturated++;
               end
            end
         end
      end
      pending <= expected_results.size();
   end

endmodule

/* sim/tb_numeric_literal_scanner_core.sv */
// Testbench top for numeric_literal_scanner_core: clock, reset, character stimulus,
// rsp back-pressure and verdict. Depends on nls_pkg, nls_checker and the block itself.
`timescale 1ns / 1ps

module tb_numeric_literal_scanner_core;
   import nls_pkg::*;

   localparam int TARGET_ITEMS = 2000;
   localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
   localparam int SETTLE       = 10;     // margin after the input and result registers drain

   // characters the package does not name
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] UMLAUT_CODES [7] = '{8'hC4, 8'hD6, 8'hDC, 8'hDF,
                                               8'hE4, 8'hF6, 8'hFC};
   localparam string DIGITS    = "0123456789";
   localparam string HEX_CHARS = "0123456789abcdefABCDEF";
   localparam string MIX_CHARS = "0123456789.-edfxXaAgGzZ?(";
   localparam string BAD_CHARS = "abcgqzAGZ?(";

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [7:0] ch
   logic [1:0]            req_tuser = '0;    // [0] first, [1] line_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [0] taken, [2:1] status, [34:3] int_value,
                                             // [41:35] length, [42] overflow, [47:43] zero
   logic                  rsp_tlast;         // done_res
   logic [1:0]            rsp_tuser;         // kind

   int fail_count, pending, n_checked, n_ok, n_syntax, n_empty, n_saturated;
   int n_items = 0;     // characters that count toward the stimulus budget
   int n_lits  = 0;
   int n_hex   = 0;
   int stall_cycles = 0;
   int rdy_hold = 0;
   int rdy_gap;
   bit quiet = 1'b0;    // when set, neither side idles

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   numeric_literal_scanner_core #(
      .MAX_LEN    (DEF_MAX_LEN),
      .HEX_DIGITS (DEF_HEX_DIGITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   nls_checker #(
      .MAX_LEN    (DEF_MAX_LEN),
      .HEX_DIGITS (DEF_HEX_DIGITS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending),
      .n_checked   (n_checked),
      .n_ok        (n_ok),
      .n_syntax    (n_syntax),
      .n_empty     (n_empty),
      .n_saturated (n_saturated)
   );

   // Idle lengths: mostly none or a few cycles, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // rsp back-pressure: short bursts of ready, random low stretches between them
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rdy_hold   <= 0;
      end else if (rdy_hold != 0) begin
         rdy_hold <= rdy_hold - 1;
      end else if (rsp_tready) begin
         rdy_gap = pick_gap();
         if (rdy_gap != 0) begin
            rsp_tready <= 1'b0;
            rdy_hold   <= rdy_gap - 1;
         end else begin
            rdy_hold <= $urandom_range(0, 7);
         end
      end else begin
         rsp_tready <= 1'b1;
         rdy_hold   <= $urandom_range(0, 7);
      end
   end

   // Watchdog: any word moving on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no word moved for %0d cycles, %0d results still due",
               STALL_LIMIT, pending);
      $display("tb_numeric_literal_scanner_core NOT OK");
      $finish;
   end

   // One character word; called at a rising edge, returns at the edge that took it.
   // With no gap, valid simply stays high into the next word.
   task automatic send_char(logic [7:0] c, logic first, logic le, bit counted);
      int g;
      g = pick_gap();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= {le, first};
      do @(posedge clock); while (req_tready !== 1'b1);
      if (counted) n_items++;
   endtask

   task automatic send_lit(string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == 0, 1'b0, 1'b1);
   endtask

   // Stop sending until every predicted result word has been checked
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [7:0] pick_from(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_junk();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return pick_from(MIX_CHARS);
      if (r < 8) return UMLAUT_CODES[$urandom_range(0, 6)];
      return 8'($urandom);
   endfunction

   // One literal: mostly well formed with random content, then some terminator.
   // A share of broken literals and raw noise with random first/line_end flags.
   task automatic random_literal();
      logic [7:0] lit [$];
      int         sel, n, r;
      logic       nf, nl;
      n_lits++;
      quiet = ($urandom_range(0, 7) == 0);
      sel   = (n_lits % 60 == 7) ? 100 : $urandom_range(0, 99);

      if (sel >= 85 && sel < 100) begin
         // noise; words with first clear mostly hit an idle scanner
         n = $urandom_range(1, 4);
         repeat (n) begin
            nf = ($urandom_range(0, 9) < 3);
            nl = ($urandom_range(0, 9) < 2);
            send_char(8'($urandom), nf, nl, nf);
         end
         return;
      end

      if (sel < 25) begin
         // decimal integer, sometimes long enough to saturate
         if ($urandom_range(0, 3) == 0) lit.push_back(CH_ZERO);
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 6);
         repeat (n) lit.push_back(pick_from(DIGITS));
      end else if (sel < 45) begin
         // decimal with point, exponent, minus and suffix in any mix
         repeat ($urandom_range(0, 4)) lit.push_back(pick_from(DIGITS));
         if ($urandom_range(0, 9) < 6) begin
            lit.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) lit.push_back(pick_from(DIGITS));
         end
         if ($urandom_range(0, 1)) begin
            lit.push_back(CH_LE);
            if ($urandom_range(0, 1)) lit.push_back(CH_MINUS);
            repeat ($urandom_range(1, 3)) lit.push_back(pick_from(DIGITS));
         end
         if ($urandom_range(0, 9) < 6) lit.push_back($urandom_range(0, 1) ? CH_LF : CH_LD);
      end else if (sel < 65) begin
         // hex; full width and one digit too many are weighted up
         n_hex++;
         lit.push_back(CH_ZERO);
         lit.push_back(($urandom_range(0, 9) == 0) ? CH_UX : CH_LX);
         r = $urandom_range(0, 99);
         n = (r < 10) ? 0 : (r < 30) ? 8 : (r < 45) ? 9 : $urandom_range(1, 7);
         repeat (n) lit.push_back(pick_from(HEX_CHARS));
      end else if (sel < 67 || sel == 100) begin
         // runs into the length limit
         repeat ($urandom_range(95, 104)) lit.push_back(pick_from(DIGITS));
      end else begin
         repeat ($urandom_range(1, 6)) lit.push_back(rand_junk());
      end
      if (lit.size() == 0) lit.push_back(pick_from(DIGITS));

      foreach (lit[i]) send_char(lit[i], i == 0, 1'b0, 1'b1);

      case ($urandom_range(0, 9))
         0: send_char(8'($urandom), 1'b0, 1'b1, 1'b1);
         1: send_char(CH_SPACE, 1'b0, 1'b0, 1'b1);
         2: send_char(CH_COMMA, 1'b0, 1'b0, 1'b1);
         3: send_char(CH_NUL, 1'b0, 1'b0, 1'b1);
         4: send_char($urandom_range(0, 1) ? pick_from(BAD_CHARS)
                                           : UMLAUT_CODES[$urandom_range(0, 6)],
                      1'b0, 1'b0, 1'b1);
         5: ;   // next literal's first character cuts this one off
         6: send_char(8'($urandom), 1'b0, 1'b0, 1'b1);
         7: send_char(CH_LE, 1'b0, 1'b0, 1'b1);
         8: send_char($urandom_range(0, 1) ? CH_LD : CH_LF, 1'b0, 1'b0, 1'b1);
         default: send_char(CH_MINUS, 1'b0, 1'b0, 1'b1);
      endcase
      if ($urandom_range(0, 4) == 0)
         send_char(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_char(CH_NINE, 1'b1, 1'b1, 1'b1);   // first together with line end: empty token
      send_lit("0x");
      send_char(CH_NUL, 1'b0, 1'b1, 1'b1);    // "0x" then line end: syntax error
      send_lit("0xFFFFFFFFa");                // all ones, then a ninth hex digit
      send_lit("9.e-1f");
      send_char(CH_LE, 1'b0, 1'b0, 1'b1);     // e right after a suffix
      send_lit("7");
      send_char(CH_NUL, 1'b0, 1'b0, 1'b1);    // byte zero just ends it
      send_lit("d");                          // suffix with nothing before it
      send_char(CH_NUL, 1'b0, 1'b1, 1'b1);    // suffix then line end
      send_lit(".q");                         // leading point, then an error letter
      send_char(CH_ZERO, 1'b0, 1'b0, 1'b0);   // idle scanner ignores this one
      drain();

      while (n_items < TARGET_ITEMS) begin
         random_literal();
         if (n_lits % 97 == 50) drain();
      end
      quiet = 1'b0;

      drain();
      repeat (SETTLE) @(posedge clock);

      $display("%0d characters over %0d literals (%0d hex), %0d result words checked",
               n_items, n_lits, n_hex, n_checked);
      $display("literal ends: %0d ok, %0d syntax error, %0d empty token, %0d saturated",
               n_ok, n_syntax, n_empty, n_saturated);
      if (fail_count == 0 && pending == 0)
         $display("tb_numeric_literal_scanner_core OK");
      else
         $display("tb_numeric_literal_scanner_core NOT OK");
      $finish;
   end

endmodule

/* sim.f */
sv/nls_pkg.sv
sv/nls_char_class.sv
sv/nls_step.sv
sv/numeric_literal_scanner_core.sv
sim/nls_checker.sv
sim/tb_numeric_literal_scanner_core.sv
